### rtl/core/pulse_peak_rate_detector_defines.svh
// assertion macros for the pulse peak rate detector
// no dependencies; taken in by the modules that carry assertions
`ifndef PULSE_PEAK_RATE_DETECTOR_DEFINES_SVH
`define PULSE_PEAK_RATE_DETECTOR_DEFINES_SVH

// consequent checked in the same cycle
`define PPRD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define PPRD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/pprd_pkg.sv
// shared constants, types and register codes of the pulse peak rate detector
// no dependencies; used by pprd_front, pprd_back, the top level and the testbench
package pprd_pkg;

    localparam int RING_DEPTH_DEF  = 16;
    localparam int SAMPLE_BITS_DEF = 18;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 18;
    localparam int THRESH_W    = 18;
    localparam int NUMER_W     = 16;
    localparam int RATE_W      = 8;
    localparam int COUNT_W     = 16;
    localparam int TALLY_W     = 4;
    localparam int DELTA_OUT_W = 19;
    localparam int M_TDATA_W   = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_FINGER_THRESHOLD = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_RISE_THRESHOLD   = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_FALL_THRESHOLD   = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_RATE_NUMERATOR   = CFG_INDEX_W'(3);
    localparam logic [CFG_INDEX_W-1:0] CFG_RATE_LOW         = CFG_INDEX_W'(4);
    localparam logic [CFG_INDEX_W-1:0] CFG_RATE_HIGH        = CFG_INDEX_W'(5);

    localparam logic [THRESH_W-1:0] FINGER_THRESHOLD_RST = THRESH_W'(50000);
    localparam logic [THRESH_W-1:0] RISE_THRESHOLD_RST   = THRESH_W'(80);
    localparam logic [THRESH_W-1:0] FALL_THRESHOLD_RST   = THRESH_W'(40);
    localparam logic [NUMER_W-1:0]  RATE_NUMERATOR_RST   = NUMER_W'(3960);
    localparam logic [RATE_W-1:0]   RATE_LOW_RST         = RATE_W'(40);
    localparam logic [RATE_W-1:0]   RATE_HIGH_RST        = RATE_W'(180);

    localparam logic [TALLY_W-1:0] TALLY_WRAP = TALLY_W'(8);

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SUM,
        BK_AVG_WAIT,
        BK_PEAK,
        BK_RATE_WAIT,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic valid;
        logic finger;
    } q_head_t;

    typedef struct packed {
        logic [THRESH_W-1:0] rise;
        logic [THRESH_W-1:0] fall;
        logic [NUMER_W-1:0]  numer;
        logic [RATE_W-1:0]   low;
        logic [RATE_W-1:0]   high;
    } back_cfg_t;

endpackage

### rtl/core/pprd_ram.sv
// generic single-port-write ram with registered read
// no dependencies
module pprd_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/pprd_div.sv
// serial restoring divider, one quotient bit per cycle
// no package dependencies; used by the back end
module pprd_div #(
    parameter int DIVIDEND_W = 22,
    parameter int DIVISOR_W  = 16,
    localparam int STEP_W = $clog2(DIVIDEND_W + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    input  logic [STEP_W-1:0]     steps,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] quotient
);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dsr_reg;
    logic [STEP_W-1:0]     cnt_reg;
    logic                  busy_reg;

    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 fits;
    logic [DIVISOR_W-1:0] rem_next;

    always_comb begin
        trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        fits     = trial >= {1'b0, dsr_reg};
        rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= steps;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

### rtl/core/pprd_front.sv
// front end: takes sample words, flags finger presence, queues them for the back end
// depends on pprd_pkg
module pprd_front #(
    parameter int SAMPLE_BITS = pprd_pkg::SAMPLE_BITS_DEF,
    parameter int S_TDATA_W   = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [S_TDATA_W-1:0]          s_tdata,
    input  logic [pprd_pkg::THRESH_W-1:0] finger_threshold,
    output pprd_pkg::q_head_t             q_head,
    output logic [SAMPLE_BITS-1:0]        q_sample,
    input  logic                          q_pop
);

    localparam int CMP_W  = (SAMPLE_BITS > pprd_pkg::THRESH_W) ? SAMPLE_BITS
                                                                : pprd_pkg::THRESH_W;
    localparam int QPTR_W = $clog2(pprd_pkg::QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(pprd_pkg::QUEUE_DEPTH + 1);

    logic [SAMPLE_BITS-1:0] smp_reg [pprd_pkg::QUEUE_DEPTH];
    logic                   fin_reg [pprd_pkg::QUEUE_DEPTH];
    logic [QPTR_W-1:0]      wr_ptr_reg;
    logic [QPTR_W-1:0]      rd_ptr_reg;
    logic [QCNT_W-1:0]      count_reg;

    logic [SAMPLE_BITS-1:0] sample;
    logic                   finger;
    logic                   push;

    always_comb begin
        sample   = s_tdata[SAMPLE_BITS-1:0];
        finger   = CMP_W'(sample) > CMP_W'(finger_threshold);
        s_tready = count_reg != QCNT_W'(pprd_pkg::QUEUE_DEPTH);
        push     = s_tvalid && s_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(pprd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                                 : wr_ptr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(pprd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                                 : rd_ptr_reg + 1'b1;
            end
            if (push && !q_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!push && q_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            smp_reg[wr_ptr_reg] <= sample;
            fin_reg[wr_ptr_reg] <= finger;
        end
    end

    assign q_head.valid  = count_reg != '0;
    assign q_head.finger = fin_reg[rd_ptr_reg];
    assign q_sample      = smp_reg[rd_ptr_reg];

endmodule

### rtl/core/pprd_back.sv
// back end: ring average, peak hysteresis, rate division and result register
// depends on pprd_pkg, pprd_ram, pprd_div and the assertion macro header
`include "pulse_peak_rate_detector_defines.svh"

module pprd_back #(
    parameter int RING_DEPTH  = pprd_pkg::RING_DEPTH_DEF,
    parameter int SAMPLE_BITS = pprd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  pprd_pkg::q_head_t              q_head,
    input  logic [SAMPLE_BITS-1:0]         q_sample,
    output logic                           q_pop,
    input  pprd_pkg::back_cfg_t            cfg,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pprd_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tuser
);

    localparam int SLOT_W  = $clog2(RING_DEPTH);
    localparam int SUM_W   = SAMPLE_BITS + SLOT_W;
    localparam int STEP_W  = $clog2(pprd_pkg::NUMER_W + 1);
    localparam bit IS_POW2 = (1 << SLOT_W) == RING_DEPTH;
    localparam int CW      = ((SAMPLE_BITS > pprd_pkg::THRESH_W) ? SAMPLE_BITS
                                                                 : pprd_pkg::THRESH_W) + 2;
    localparam int COUNT_W = pprd_pkg::COUNT_W;
    localparam int TALLY_W = pprd_pkg::TALLY_W;
    localparam int RATE_W  = pprd_pkg::RATE_W;
    localparam int NUMER_W = pprd_pkg::NUMER_W;
    localparam int DOUT_W  = pprd_pkg::DELTA_OUT_W;

    // average by reciprocal multiplication, most significant 16-bit chunk first
    localparam int CHUNK_W = 16;
    localparam int RECIP_W = ((SUM_W + 2 + CHUNK_W - 1) / CHUNK_W) * CHUNK_W;
    localparam int NCHUNK  = RECIP_W / CHUNK_W;
    localparam int MCNT_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int PART_W  = SUM_W + CHUNK_W;
    localparam logic [63:0] RECIP_FULL = ((64'd1 << (SUM_W + SLOT_W)) + 64'(RING_DEPTH - 1))
                                         / 64'(RING_DEPTH);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    pprd_pkg::back_state_t state_reg, state_next;

    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   fin_reg;
    logic [DOUT_W-1:0]      delta_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SAMPLE_BITS-1:0] prev_avg_reg;
    logic [RATE_W-1:0]      held_reg;
    logic [COUNT_W-1:0]     ssp_reg;
    logic                   inside_reg;
    logic [TALLY_W-1:0]     tally_reg;
    logic [RING_DEPTH-1:0]  valid_reg;
    logic                   m_tvalid_reg;
    logic [RATE_W-1:0]      m_rate_reg;
    logic [DOUT_W-1:0]      m_delta_reg;
    logic                   m_fin_reg;
    logic [MCNT_W-1:0]      mcnt_reg;
    logic [PROD_W-1:0]      prod_reg;

    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic                   ram_we;
    logic [SAMPLE_BITS-1:0] old_sample;
    logic [SUM_W-1:0]       sum_upd;
    logic [CHUNK_W-1:0]     recip_chunk;
    logic [PART_W-1:0]      prod_part;
    logic [PROD_W-1:0]      prod_next;
    logic [SAMPLE_BITS-1:0] avg;
    logic signed [CW-1:0]   delta;
    logic signed [CW-1:0]   rise_s;
    logic signed [CW-1:0]   fall_neg;
    logic                   peak_start;
    logic                   peak_end;
    logic [TALLY_W-1:0]     tally_inc;
    logic [NUMER_W-1:0]     rate;
    logic                   in_band;
    logic                   m_load;

    logic               div_start;
    logic               div_busy;
    logic [NUMER_W-1:0] div_dividend;
    logic [COUNT_W-1:0] div_divisor;
    logic [STEP_W-1:0]  div_steps;
    logic [NUMER_W-1:0] div_quo;

    pprd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (sample_reg),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    pprd_div #(
        .DIVIDEND_W (NUMER_W),
        .DIVISOR_W  (COUNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // datapath
    always_comb begin
        ram_we      = state_reg == pprd_pkg::BK_SUM;
        old_sample  = valid_reg[slot_reg] ? ram_rdata : '0;
        sum_upd     = sum_reg - SUM_W'(old_sample) + SUM_W'(sample_reg);
        recip_chunk = CHUNK_W'(RECIP >> {mcnt_reg, 4'b0000});
        prod_part   = PART_W'(sum_reg) * PART_W'(recip_chunk);
        prod_next   = {prod_reg[PROD_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}} + PROD_W'(prod_part);
        if (IS_POW2) begin
            avg = SAMPLE_BITS'(sum_reg >> SLOT_W);
        end else begin
            avg = SAMPLE_BITS'(prod_reg >> (SUM_W + SLOT_W));
        end
        delta        = signed'(CW'(prev_avg_reg)) - signed'(CW'(avg));
        rise_s       = signed'(CW'(cfg.rise));
        fall_neg     = -signed'(CW'(cfg.fall));
        peak_start   = (delta > rise_s) && !inside_reg;
        peak_end     = delta < fall_neg;
        tally_inc    = tally_reg + 1'b1;
        rate         = div_quo;
        in_band      = (rate >= NUMER_W'(cfg.low)) && (rate <= NUMER_W'(cfg.high));
        div_dividend = cfg.numer;
        div_divisor  = ssp_reg;
        div_steps    = STEP_W'(NUMER_W);
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        div_start  = 1'b0;
        m_load     = 1'b0;
        case (state_reg)
            pprd_pkg::BK_IDLE: begin
                if (q_head.valid) begin
                    q_pop      = 1'b1;
                    state_next = q_head.finger ? pprd_pkg::BK_SUM : pprd_pkg::BK_EMIT;
                end
            end
            pprd_pkg::BK_SUM: begin
                if (IS_POW2) begin
                    state_next = pprd_pkg::BK_PEAK;
                end else begin
                    state_next = pprd_pkg::BK_AVG_WAIT;
                end
            end
            pprd_pkg::BK_AVG_WAIT: begin
                if (mcnt_reg == '0) begin
                    state_next = pprd_pkg::BK_PEAK;
                end
            end
            pprd_pkg::BK_PEAK: begin
                if (peak_start && tally_inc >= TALLY_W'(2)) begin
                    div_start  = 1'b1;
                    state_next = pprd_pkg::BK_RATE_WAIT;
                end else begin
                    state_next = pprd_pkg::BK_EMIT;
                end
            end
            pprd_pkg::BK_RATE_WAIT: begin
                if (!div_busy) begin
                    state_next = pprd_pkg::BK_EMIT;
                end
            end
            pprd_pkg::BK_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_load     = 1'b1;
                    state_next = pprd_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = pprd_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pprd_pkg::BK_IDLE;
            slot_reg     <= '0;
            sum_reg      <= '0;
            prev_avg_reg <= '0;
            held_reg     <= '0;
            ssp_reg      <= '0;
            inside_reg   <= 1'b0;
            tally_reg    <= '0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                pprd_pkg::BK_IDLE: begin
                    // no finger: back to the reset picture
                    if (q_pop && !q_head.finger) begin
                        slot_reg     <= '0;
                        sum_reg      <= '0;
                        prev_avg_reg <= '0;
                        held_reg     <= '0;
                        ssp_reg      <= '0;
                        inside_reg   <= 1'b0;
                        tally_reg    <= '0;
                        valid_reg    <= '0;
                    end
                end
                pprd_pkg::BK_SUM: begin
                    sum_reg             <= sum_upd;
                    valid_reg[slot_reg] <= 1'b1;
                    slot_reg <= (slot_reg == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
                    if (ssp_reg != '1) begin
                        ssp_reg <= ssp_reg + 1'b1;
                    end
                end
                pprd_pkg::BK_PEAK: begin
                    prev_avg_reg <= avg;
                    if (peak_start) begin
                        inside_reg <= 1'b1;
                        ssp_reg    <= '0;
                        tally_reg  <= (tally_inc > pprd_pkg::TALLY_WRAP) ? TALLY_W'(1)
                                                                        : tally_inc;
                    end else if (peak_end) begin
                        inside_reg <= 1'b0;
                    end
                end
                pprd_pkg::BK_RATE_WAIT: begin
                    if (!div_busy && in_band) begin
                        held_reg <= rate[RATE_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            sample_reg <= q_sample;
            fin_reg    <= q_head.finger;
            delta_reg  <= '0;
        end
        if (state_reg == pprd_pkg::BK_SUM) begin
            prod_reg <= '0;
            mcnt_reg <= MCNT_W'(NCHUNK - 1);
        end
        if (state_reg == pprd_pkg::BK_AVG_WAIT) begin
            prod_reg <= prod_next;
            mcnt_reg <= mcnt_reg - 1'b1;
        end
        if (state_reg == pprd_pkg::BK_PEAK) begin
            delta_reg <= delta[DOUT_W-1:0];
        end
        if (m_load) begin
            m_rate_reg  <= held_reg;
            m_delta_reg <= delta_reg;
            m_fin_reg   <= fin_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = pprd_pkg::M_TDATA_W'({m_delta_reg, m_rate_reg});
    assign m_tuser  = m_fin_reg;

    `PPRD_ASSERT_NEXT(a_clear_on_no_finger, aclk, aresetn, (state_reg == pprd_pkg::BK_IDLE && q_pop && !q_head.finger), (held_reg == '0 && tally_reg == '0 && !inside_reg && valid_reg == '0), "no-finger word did not clear state")
    `PPRD_ASSERT_NOW(a_div_free_at_start, aclk, aresetn, div_start, !div_busy, "divider started while busy")
    `PPRD_ASSERT_NOW(a_pop_needs_word, aclk, aresetn, q_pop, (q_head.valid && state_reg == pprd_pkg::BK_IDLE), "queue popped without a waiting word")
    `PPRD_ASSERT_NEXT(a_tally_wrap, aclk, aresetn, (state_reg == pprd_pkg::BK_PEAK && peak_start && tally_reg == pprd_pkg::TALLY_WRAP), (tally_reg == TALLY_W'(1)), "peak tally did not wrap to one")

endmodule

### rtl/core/pulse_peak_rate_detector.sv
// Optical pulse-rate detector: one infrared sample word in, one result word out. The front end
// flags finger presence and queues up to two words; the back end keeps a ring average, finds
// peaks with hysteresis on the average delta, and divides the rate numerator by the samples
// between peaks. A word with a finger passes the back end's idle, sum, peak and emit states when
// RING_DEPTH is a power of two; other depths add an averaging wait state that forms the average
// by a reciprocal multiplication taken 16 bits per cycle. A word that starts the second or later
// peak adds a rate wait state for the serial rate quotient. A word without a finger passes only
// the idle and emit states and clears the ring at once through per-entry valid bits, so no
// clearing pass follows reset. A stalled result port holds the back end in its emit state.
// depends on pprd_pkg, pprd_front, pprd_back
module pulse_peak_rate_detector #(
    parameter int RING_DEPTH  = pprd_pkg::RING_DEPTH_DEF,
    parameter int SAMPLE_BITS = pprd_pkg::SAMPLE_BITS_DEF,
    localparam int S_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [S_TDATA_W-1:0]             s_tdata,   // ir_sample
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [pprd_pkg::M_TDATA_W-1:0]   m_tdata,   // heart_rate, average_delta
    output logic                             m_tuser,   // finger_present
    input  logic                             cfg_we,
    input  logic [pprd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pprd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    logic [pprd_pkg::THRESH_W-1:0] finger_thr_reg;
    logic [pprd_pkg::THRESH_W-1:0] rise_thr_reg;
    logic [pprd_pkg::THRESH_W-1:0] fall_thr_reg;
    logic [pprd_pkg::NUMER_W-1:0]  numer_reg;
    logic [pprd_pkg::RATE_W-1:0]   rate_low_reg;
    logic [pprd_pkg::RATE_W-1:0]   rate_high_reg;

    pprd_pkg::back_cfg_t    back_cfg;
    pprd_pkg::q_head_t      q_head;
    logic [SAMPLE_BITS-1:0] q_sample;
    logic                   q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            finger_thr_reg <= pprd_pkg::FINGER_THRESHOLD_RST;
            rise_thr_reg   <= pprd_pkg::RISE_THRESHOLD_RST;
            fall_thr_reg   <= pprd_pkg::FALL_THRESHOLD_RST;
            numer_reg      <= pprd_pkg::RATE_NUMERATOR_RST;
            rate_low_reg   <= pprd_pkg::RATE_LOW_RST;
            rate_high_reg  <= pprd_pkg::RATE_HIGH_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                pprd_pkg::CFG_FINGER_THRESHOLD: begin
                    finger_thr_reg <= cfg_wdata[pprd_pkg::THRESH_W-1:0];
                end
                pprd_pkg::CFG_RISE_THRESHOLD: begin
                    rise_thr_reg <= cfg_wdata[pprd_pkg::THRESH_W-1:0];
                end
                pprd_pkg::CFG_FALL_THRESHOLD: begin
                    fall_thr_reg <= cfg_wdata[pprd_pkg::THRESH_W-1:0];
                end
                pprd_pkg::CFG_RATE_NUMERATOR: begin
                    numer_reg <= cfg_wdata[pprd_pkg::NUMER_W-1:0];
                end
                pprd_pkg::CFG_RATE_LOW: begin
                    rate_low_reg <= cfg_wdata[pprd_pkg::RATE_W-1:0];
                end
                pprd_pkg::CFG_RATE_HIGH: begin
                    rate_high_reg <= cfg_wdata[pprd_pkg::RATE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign back_cfg.rise  = rise_thr_reg;
    assign back_cfg.fall  = fall_thr_reg;
    assign back_cfg.numer = numer_reg;
    assign back_cfg.low   = rate_low_reg;
    assign back_cfg.high  = rate_high_reg;

    pprd_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .S_TDATA_W   (S_TDATA_W)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .finger_threshold (finger_thr_reg),
        .q_head           (q_head),
        .q_sample         (q_sample),
        .q_pop            (q_pop)
    );

    pprd_back #(
        .RING_DEPTH  (RING_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_head   (q_head),
        .q_sample (q_sample),
        .q_pop    (q_pop),
        .cfg      (back_cfg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

### sim/tb_pulse_peak_rate_detector.sv
// self-checking testbench for pulse_peak_rate_detector: random stream stalls, phased register
// settings and a built-in tracker of ring average, peak hysteresis and rate per sample word
// depends on pprd_pkg and pulse_peak_rate_detector
module tb_pulse_peak_rate_detector;

    import pprd_pkg::*;

    localparam int SAMPLE_W   = SAMPLE_BITS_DEF;
    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
    localparam int SUM_W      = SAMPLE_W + $clog2(RING_DEPTH_DEF);
    localparam int IDLE_PCT   = 21;
    localparam int SETTLE_CYC = 40;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = CFG_INDEX_W'(6);
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = CFG_INDEX_W'(7);

    typedef struct packed {
        logic [RATE_W-1:0]             heart_rate;
        logic                          finger_present;
        logic signed [DELTA_OUT_W-1:0] average_delta;
    } pulse_reading_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [23:0]            s_tdata   = '0;    // ir_sample
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;           // heart_rate, average_delta
    logic                   m_tuser;           // finger_present
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    pulse_peak_rate_detector i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // register mirror
    logic [THRESH_W-1:0] finger_level = FINGER_THRESHOLD_RST;
    logic [THRESH_W-1:0] rise_level   = RISE_THRESHOLD_RST;
    logic [THRESH_W-1:0] fall_level   = FALL_THRESHOLD_RST;
    logic [NUMER_W-1:0]  bpm_numer    = RATE_NUMERATOR_RST;
    logic [RATE_W-1:0]   bpm_floor    = RATE_LOW_RST;
    logic [RATE_W-1:0]   bpm_ceiling  = RATE_HIGH_RST;

    // tracker state
    logic [SAMPLE_W-1:0] ring [RING_DEPTH_DEF];
    logic [3:0]          ring_slot;
    logic [SUM_W-1:0]    ring_total;
    logic [SAMPLE_W-1:0] last_average;
    logic [RATE_W-1:0]   held_bpm;
    logic [COUNT_W-1:0]  since_peak;
    logic                in_peak;
    logic [TALLY_W-1:0]  peak_count;

    logic [SAMPLE_W-1:0] pending_samples [$];
    pulse_reading_t      expected_readings [$];
    int                  errors = 0;
    bit                  calm   = 1'b0;

    task automatic clear_tracker();
        foreach (ring[k]) ring[k] = '0;
        ring_slot    = '0;
        ring_total   = '0;
        last_average = '0;
        held_bpm     = '0;
        since_peak   = '0;
        in_peak      = 1'b0;
        peak_count   = '0;
    endtask

    task automatic track_sample(input logic [SAMPLE_W-1:0] sample);
        pulse_reading_t      r;
        logic [SAMPLE_W-1:0] avg;
        longint              diff;
        logic [COUNT_W-1:0]  bpm;
        r = '0;
        if (sample <= finger_level) begin
            clear_tracker();
        end else begin
            ring_total      = ring_total - ring[ring_slot] + sample;
            ring[ring_slot] = sample;
            ring_slot       = ring_slot + 4'd1;
            if (since_peak != {COUNT_W{1'b1}})
                since_peak = since_peak + 1'b1;
            avg  = SAMPLE_W'(ring_total / RING_DEPTH_DEF);
            diff = longint'(last_average) - longint'(avg);
            if (diff > longint'(rise_level) && !in_peak) begin
                in_peak    = 1'b1;
                peak_count = peak_count + 1'b1;
                if (peak_count >= TALLY_W'(2)) begin
                    bpm = bpm_numer / since_peak;
                    if (bpm >= bpm_floor && bpm <= bpm_ceiling)
                        held_bpm = bpm[RATE_W-1:0];
                end
                since_peak = '0;
                if (peak_count > TALLY_WRAP)
                    peak_count = TALLY_W'(1);
            end else if (diff < -longint'(fall_level)) begin
                in_peak = 1'b0;
            end
            last_average     = avg;
            r.heart_rate     = held_bpm;
            r.finger_present = 1'b1;
            r.average_delta  = diff[DELTA_OUT_W-1:0];
        end
        expected_readings.push_back(r);
    endtask

    initial clear_tracker();

    // sample word driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                track_sample(s_tdata[SAMPLE_W-1:0]);
            if (!s_tvalid || s_tready) begin
                if (pending_samples.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(24 - SAMPLE_W){1'b0}}, pending_samples.pop_front()};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result word monitor
    always @(posedge aclk) begin : reading_check
        pulse_reading_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            if (m_tvalid && m_tready) begin
                if (expected_readings.size() == 0) begin
                    $error("unexpected result word %h", m_tdata);
                    errors++;
                end else begin
                    want = expected_readings.pop_front();
                    if (m_tdata[RATE_W-1:0] !== want.heart_rate) begin
                        $error("heart_rate: expected %0d, got %0d",
                               want.heart_rate, m_tdata[RATE_W-1:0]);
                        errors++;
                    end
                    if (m_tuser !== want.finger_present) begin
                        $error("finger_present: expected %0d, got %0d",
                               want.finger_present, m_tuser);
                        errors++;
                    end
                    if (m_tdata[RATE_W +: DELTA_OUT_W] !== want.average_delta) begin
                        $error("average_delta: expected %0d, got %0d", want.average_delta,
                               $signed(m_tdata[RATE_W +: DELTA_OUT_W]));
                        errors++;
                    end
                end
            end
        end
    end

    // bits above a narrow register's width carry random junk
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        logic [CFG_DATA_W-1:0] bus;
        bus = CFG_DATA_W'(value);
        case (idx)
            CFG_RATE_NUMERATOR: bus[CFG_DATA_W-1:NUMER_W] = (CFG_DATA_W - NUMER_W)'($urandom);
            CFG_RATE_LOW, CFG_RATE_HIGH: bus[CFG_DATA_W-1:RATE_W] = (CFG_DATA_W - RATE_W)'($urandom);
            CFG_SPARE_LO, CFG_SPARE_HI: bus = CFG_DATA_W'($urandom);
            default: ;
        endcase
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= bus;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_FINGER_THRESHOLD: finger_level = bus[THRESH_W-1:0];
            CFG_RISE_THRESHOLD:   rise_level   = bus[THRESH_W-1:0];
            CFG_FALL_THRESHOLD:   fall_level   = bus[THRESH_W-1:0];
            CFG_RATE_NUMERATOR:   bpm_numer    = bus[NUMER_W-1:0];
            CFG_RATE_LOW:         bpm_floor    = bus[RATE_W-1:0];
            CFG_RATE_HIGH:        bpm_ceiling  = bus[RATE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic settle();
        while (pending_samples.size() != 0 || s_tvalid || expected_readings.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    // pulse trains above the finger level, mixed with noise and finger dropouts
    task automatic queue_waveforms(input int count);
        int added;
        int kind;
        int len;
        int period;
        int floor_v;
        int base;
        int amp;
        int v;
        added = 0;
        while (added < count) begin
            kind    = $urandom_range(9);
            floor_v = (int'(finger_level) < SAMPLE_MAX) ? int'(finger_level) + 1 : SAMPLE_MAX;
            if (kind == 0) begin
                len = $urandom_range(20, 4);
                repeat (len) pending_samples.push_back(SAMPLE_W'($urandom));
            end else if (kind == 1) begin
                len = $urandom_range(3, 1);
                repeat (len) pending_samples.push_back(SAMPLE_W'($urandom_range(finger_level)));
            end else begin
                len    = $urandom_range(200, 40);
                period = ($urandom_range(3) == 0) ? $urandom_range(12, 2) : $urandom_range(100, 20);
                base   = floor_v + $urandom_range((SAMPLE_MAX - floor_v) / 2);
                amp    = $urandom_range(SAMPLE_MAX - base);
                for (int k = 0; k < len; k++) begin
                    v = base + (((k % period) < period / 2) ? amp : 0)
                        + $urandom_range(amp / 64 + 8);
                    if (v > SAMPLE_MAX)
                        v = SAMPLE_MAX;
                    pending_samples.push_back(SAMPLE_W'(v));
                end
            end
            added += len;
        end
    endtask

    initial begin : stimulus
        int opening [23] = '{0, 50000, SAMPLE_MAX, 50001,
                             SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                             60000, 60000, 60000, 60000,
                             SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                             60000, 60000, 60000, 60000, 131072, 0};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: threshold edges, full-scale samples, square pulses
        foreach (opening[k]) pending_samples.push_back(SAMPLE_W'(opening[k]));
        settle();
        queue_waveforms(260);
        settle();

        // zero numerator and the full band
        write_reg(CFG_RATE_NUMERATOR, 0);
        write_reg(CFG_RATE_LOW, 0);
        write_reg(CFG_RATE_HIGH, 255);
        queue_waveforms(160);
        settle();

        // empty band, zero hysteresis, largest numerator
        write_reg(CFG_RATE_NUMERATOR, 65535);
        write_reg(CFG_RATE_LOW, 200);
        write_reg(CFG_RATE_HIGH, 100);
        write_reg(CFG_RISE_THRESHOLD, 0);
        write_reg(CFG_FALL_THRESHOLD, 0);
        queue_waveforms(160);
        settle();

        // top thresholds: no sample can count as a finger; spare indexes do nothing
        write_reg(CFG_FINGER_THRESHOLD, SAMPLE_MAX);
        write_reg(CFG_RISE_THRESHOLD, SAMPLE_MAX);
        write_reg(CFG_FALL_THRESHOLD, SAMPLE_MAX);
        write_reg(CFG_RATE_LOW, 0);
        write_reg(CFG_RATE_HIGH, 0);
        write_reg(CFG_SPARE_LO, 0);
        write_reg(CFG_SPARE_HI, 0);
        queue_waveforms(40);
        settle();

        // random settings with the finger level at zero
        write_reg(CFG_FINGER_THRESHOLD, 0);
        write_reg(CFG_RISE_THRESHOLD, $urandom_range(2000));
        write_reg(CFG_FALL_THRESHOLD, $urandom_range(2000));
        write_reg(CFG_RATE_NUMERATOR, $urandom_range(65535, 1));
        write_reg(CFG_RATE_LOW, $urandom_range(100));
        write_reg(CFG_RATE_HIGH, $urandom_range(255, 100));
        queue_waveforms(220);
        settle();

        // square pulses, a flat run and a late peak, no idling on either side
        write_reg(CFG_FINGER_THRESHOLD, FINGER_THRESHOLD_RST);
        write_reg(CFG_RISE_THRESHOLD, RISE_THRESHOLD_RST);
        write_reg(CFG_FALL_THRESHOLD, FALL_THRESHOLD_RST);
        write_reg(CFG_RATE_NUMERATOR, 65535);
        write_reg(CFG_RATE_LOW, 0);
        write_reg(CFG_RATE_HIGH, 255);
        calm = 1'b1;
        pending_samples.push_back('0);
        for (int k = 0; k < 60; k++)
            pending_samples.push_back(SAMPLE_W'(((k % 20) < 10) ? 200000 : 100000));
        repeat (100) pending_samples.push_back(SAMPLE_W'(200000));
        repeat (10) pending_samples.push_back(SAMPLE_W'(100000));
        repeat (10) pending_samples.push_back(SAMPLE_W'(200000));
        settle();
        calm = 1'b0;

        // back to reset values
        write_reg(CFG_RATE_NUMERATOR, RATE_NUMERATOR_RST);
        write_reg(CFG_RATE_LOW, RATE_LOW_RST);
        write_reg(CFG_RATE_HIGH, RATE_HIGH_RST);
        queue_waveforms(100);
        settle();

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
